FILE: rtl/hrsp_pkg.sv
// Shared types, character constants and matcher functions of the HTTP request parser.
package hrsp_pkg;

	// Phase codes
	localparam logic [1:0] PH_HEAD = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_BAD  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [1:0] ST_COMPLETE   = 2'd1;
	localparam logic [1:0] ST_MALFORMED  = 2'd2;

	// Register indexes
	localparam logic CFG_MAX_HEADER = 1'b0;
	localparam logic CFG_MAX_BODY   = 1'b1;

	// Line position codes
	localparam logic [3:0] LP_METHOD      = 4'd0;
	localparam logic [3:0] LP_TARGET      = 4'd1;
	localparam logic [3:0] LP_VERSION     = 4'd2;
	localparam logic [3:0] LP_NAME_LEAD   = 4'd3;
	localparam logic [3:0] LP_NAME        = 4'd4;
	localparam logic [3:0] LP_NAME_TRAIL  = 4'd5;
	localparam logic [3:0] LP_VALUE_LEAD  = 4'd6;
	localparam logic [3:0] LP_VALUE       = 4'd7;
	localparam logic [3:0] LP_VALUE_TRAIL = 4'd8;

	localparam logic [4:0]  MATCH_FAIL        = 5'd31;
	localparam logic [3:0]  MAX_LENGTH_DIGITS = 4'd10;
	localparam logic [34:0] LEN_LIMIT         = 35'h07FFFFFFF;
	localparam logic [15:0] CNT_MAX           = 16'hFFFF;
	localparam logic [16:0] HBC_MAX           = 17'h1FFFF;

	localparam logic [15:0] MAX_HEADER_RESET = 16'd8192;
	localparam logic [30:0] MAX_BODY_RESET   = 31'd1048576;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Header names left aligned in 17 bytes, values in 8 bytes, version prefix in 5 bytes
	localparam logic [8*17-1:0] NAME_CL = {"content-length", 24'h0};
	localparam logic [8*17-1:0] NAME_TE = "transfer-encoding";
	localparam logic [8*17-1:0] NAME_CN = {"connection", 56'h0};
	localparam logic [8*8-1:0]  VAL_TE  = "identity";
	localparam logic [8*8-1:0]  VAL_CN  = {"close", 24'h0};
	localparam logic [8*5-1:0]  VER_TXT = "HTTP/";

	// Per-request line parsing state
	typedef struct packed {
		logic [3:0]      lp;
		logic [15:0]     mcnt;
		logic [15:0]     tcnt;
		logic [2:0]      ver;
		logic [2:0][4:0] nm;
		logic [2:0][4:0] vm;
		logic [2:0]      seen;
		logic [30:0]     acc;
		logic [3:0]      digits;
		logic [1:0]      err;
	} line_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB;
	endfunction

	function automatic logic [4:0] hdr_len(input logic [1:0] i);
		case (i)
			2'd0: return 5'd14;
			2'd1: return 5'd17;
			2'd2: return 5'd10;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [4:0] val_len(input logic [1:0] i);
		case (i)
			2'd1: return 5'd8;
			2'd2: return 5'd5;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [7:0] name_char(input logic [1:0] i, input logic [4:0] k);
		logic [4:0] idx;
		idx = 5'd16 - k;
		case (i)
			2'd0: return NAME_CL[{idx, 3'b000} +: 8];
			2'd1: return NAME_TE[{idx, 3'b000} +: 8];
			2'd2: return NAME_CN[{idx, 3'b000} +: 8];
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] val_char(input logic [1:0] i, input logic [4:0] k);
		logic [2:0] idx;
		idx = 3'd7 - k[2:0];
		case (i)
			2'd1: return VAL_TE[{idx, 3'b000} +: 8];
			2'd2: return VAL_CN[{idx, 3'b000} +: 8];
			default: return 8'd0;
		endcase
	endfunction

	// First fully matched name not yet seen: {hit, slot}
	function automatic logic [2:0] active_slot(input line_t s);
		logic [2:0] r;
		r = 3'b000;
		for (int i = 2; i >= 0; i--) begin
			if (s.nm[i] == hdr_len(2'(i)) && !s.seen[i])
				r = {1'b1, 2'(i)};
		end
		return r;
	endfunction

	function automatic line_t name_feed(input line_t s, input logic [7:0] c);
		line_t r;
		r = s;
		for (int i = 0; i < 3; i++) begin
			if (s.nm[i] != MATCH_FAIL) begin
				if (s.nm[i] < hdr_len(2'(i)) && to_lower(c) == name_char(2'(i), s.nm[i]))
					r.nm[i] = s.nm[i] + 5'd1;
				else
					r.nm[i] = MATCH_FAIL;
			end
		end
		return r;
	endfunction

	function automatic line_t value_feed(input line_t s, input logic [7:0] c);
		line_t      r;
		logic [2:0] as;
		logic [1:0] sl;
		logic [34:0] v;
		logic [4:0] k;
		r  = s;
		as = active_slot(s);
		sl = as[1:0];
		if (!as[2] || s.vm[sl] == MATCH_FAIL)
			return r;
		if (sl == 2'd0) begin
			// acc * 10 + digit
			v = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {31'b0, c[3:0]};
			if (c < "0" || c > "9" || s.digits >= MAX_LENGTH_DIGITS || v > LEN_LIMIT) begin
				r.vm[0] = MATCH_FAIL;
			end else begin
				r.acc    = v[30:0];
				r.digits = s.digits + 4'd1;
				r.vm[0]  = 5'd1;
			end
		end else begin
			k = s.vm[sl];
			if (k < val_len(sl) && to_lower(c) == val_char(sl, k))
				r.vm[sl] = k + 5'd1;
			else
				r.vm[sl] = MATCH_FAIL;
		end
		return r;
	endfunction

	// One ordinary line character
	function automatic line_t line_char(input line_t s, input logic [7:0] c);
		line_t      r;
		logic [2:0] as;
		r = s;
		case (s.lp)
			LP_METHOD: begin
				if (c == CH_SP) r.lp = LP_TARGET;
				else if (s.mcnt < CNT_MAX) r.mcnt = s.mcnt + 16'd1;
			end
			LP_TARGET: begin
				if (c == CH_SP) r.lp = LP_VERSION;
				else if (s.tcnt < CNT_MAX) r.tcnt = s.tcnt + 16'd1;
			end
			LP_VERSION: begin
				if (s.ver < 3'd5)
					r.ver = (c == VER_TXT[{3'd4 - s.ver, 3'b000} +: 8]) ? s.ver + 3'd1 : 3'd7;
			end
			LP_NAME_LEAD: begin
				if (is_blank(c)) begin
				end else if (c == CH_COLON) begin
					r.err = s.err | 2'b10;
					r.lp  = LP_VALUE_LEAD;
				end else begin
					r    = name_feed(s, c);
					r.lp = LP_NAME;
				end
			end
			LP_NAME: begin
				if (is_blank(c)) r.lp = LP_NAME_TRAIL;
				else if (c == CH_COLON) r.lp = LP_VALUE_LEAD;
				else r = name_feed(s, c);
			end
			LP_NAME_TRAIL: begin
				if (is_blank(c)) begin
				end else if (c == CH_COLON) begin
					r.lp = LP_VALUE_LEAD;
				end else begin
					r.nm = {3{MATCH_FAIL}};
					r.lp = LP_NAME;
				end
			end
			LP_VALUE_LEAD: begin
				if (!is_blank(c)) begin
					r    = value_feed(s, c);
					r.lp = LP_VALUE;
				end
			end
			LP_VALUE: begin
				if (is_blank(c)) r.lp = LP_VALUE_TRAIL;
				else r = value_feed(s, c);
			end
			LP_VALUE_TRAIL: begin
				if (!is_blank(c)) begin
					as = active_slot(s);
					if (as[2]) r.vm[as[1:0]] = MATCH_FAIL;
					r.lp = LP_VALUE;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// CR LF seen on a line
	function automatic line_t line_end(input line_t s);
		line_t      r;
		logic [2:0] as;
		r  = s;
		as = active_slot(s);
		if (s.lp <= LP_VERSION) begin
			if (!(s.lp == LP_VERSION && s.ver == 3'd5 && s.mcnt != 16'd0 && s.tcnt != 16'd0))
				r.err = s.err | 2'b01;
		end else if (s.lp <= LP_NAME_TRAIL) begin
			r.err = s.err | 2'b10;
		end else if (as[2]) begin
			r.seen[as[1:0]] = 1'b1;
		end
		r.nm = '0;
		r.lp = LP_NAME_LEAD;
		return r;
	endfunction

	function automatic logic [30:0] declared_length(input line_t s);
		return (s.seen[0] && s.vm[0] == 5'd1) ? s.acc : 31'd0;
	endfunction

	function automatic logic [16:0] header_end(input logic [16:0] hbc);
		return (hbc >= 17'd4) ? hbc - 17'd4 : 17'd0;
	endfunction

	function automatic logic limits_bad(input logic [16:0] hbc, input line_t s,
			input logic [15:0] max_h, input logic [30:0] max_b);
		return header_end(hbc) > {1'b0, max_h} || declared_length(s) > max_b;
	endfunction

	function automatic logic head_bad(input logic [16:0] hbc, input line_t s,
			input logic [15:0] max_h, input logic [30:0] max_b);
		if (s.err != 2'b00) return 1'b1;
		if (s.seen[0] && s.vm[0] == MATCH_FAIL) return 1'b1;
		if (s.seen[1] && s.vm[1] != 5'd0 && s.vm[1] != 5'd8) return 1'b1;
		return limits_bad(hbc, s, max_h, max_b);
	endfunction

endpackage

FILE: rtl/http_request_stream_parser_top.sv
// Top level of the streaming HTTP request head parser.
//
// Channel  Handshake              Payload
// in       in_valid / in_ready    byte_in
// out      out_valid / out_ready  status, byte_out, body_valid, content_length,
//                                 header_length, method_length, target_length, keep_alive
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled; each result appears in the cycle after its item is accepted.
// The parse state is updated at acceptance; the result sits in an output register.
// An item is taken while a result waits, as long as that result leaves the same cycle.
// Reset sets both limit registers to their defaults and starts a fresh request.
// cfg_ready is always high.
module http_request_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  byte_out,
	output logic        body_valid,
	output logic [30:0] content_length,
	output logic [15:0] header_length,
	output logic [15:0] method_length,
	output logic [15:0] target_length,
	output logic        keep_alive,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);
	import hrsp_pkg::*;

	logic [15:0] max_hdr_q;
	logic [30:0] max_body_q;
	logic [1:0]  phase_q, phase_d;
	logic [1:0]  term_q, term_d;
	logic        pend_q, pend_d;
	logic [16:0] hbc_q, hbc_d;
	line_t       ln_q, ln_d;
	logic [30:0] rem_q, rem_d;

	logic        out_valid_q;
	logic [1:0]  r_status;
	logic        r_body;
	logic [30:0] r_cl;
	logic [15:0] r_hl, r_ml, r_tl;
	logic        r_ka;
	logic        found;
	logic        emit;
	logic        in_acc;
	logic [16:0] hdr_end;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Next state and result for one item
	always_comb begin
		phase_d  = phase_q;
		term_d   = term_q;
		pend_d   = pend_q;
		hbc_d    = hbc_q;
		ln_d     = ln_q;
		rem_d    = rem_q;
		r_status = ST_INCOMPLETE;
		r_body   = 1'b0;
		emit     = 1'b0;
		found    = 1'b0;
		if (phase_q == PH_BAD) begin
			r_status = ST_MALFORMED;
		end else if (phase_q == PH_BODY) begin
			if (limits_bad(hbc_q, ln_q, max_hdr_q, max_body_q)) begin
				phase_d  = PH_BAD;
				r_status = ST_MALFORMED;
			end else begin
				r_body = 1'b1;
				if (rem_q != 31'd0) rem_d = rem_q - 31'd1;
				if (rem_d == 31'd0) emit = 1'b1;
			end
		end else begin
			if (hbc_q < HBC_MAX) hbc_d = hbc_q + 17'd1;
			found = (term_q == 2'd3 && byte_in == CH_LF);
			if (byte_in == CH_CR) term_d = (term_q == 2'd2) ? 2'd3 : 2'd1;
			else if (byte_in == CH_LF && term_q == 2'd1) term_d = 2'd2;
			else term_d = 2'd0;
			if (found) begin
				pend_d = 1'b0;
				if (head_bad(hbc_d, ln_q, max_hdr_q, max_body_q)) begin
					phase_d  = PH_BAD;
					r_status = ST_MALFORMED;
				end else if (declared_length(ln_q) == 31'd0) begin
					emit = 1'b1;
				end else begin
					rem_d   = declared_length(ln_q);
					phase_d = PH_BODY;
				end
			end else begin
				// Held CR resolves against this byte
				if (pend_q) begin
					if (byte_in == CH_LF) begin
						pend_d = 1'b0;
						ln_d   = line_end(ln_q);
					end else begin
						ln_d = line_char(ln_q, CH_CR);
						if (byte_in != CH_CR) begin
							pend_d = 1'b0;
							ln_d   = line_char(ln_d, byte_in);
						end
					end
				end else if (byte_in == CH_CR) begin
					pend_d = 1'b1;
				end else begin
					ln_d = line_char(ln_q, byte_in);
				end
				if (hbc_d > {1'b0, max_hdr_q}) begin
					phase_d  = PH_BAD;
					r_status = ST_MALFORMED;
				end
			end
		end
		// Completion report, then fresh request
		hdr_end = header_end(hbc_d);
		r_cl = '0;
		r_hl = '0;
		r_ml = '0;
		r_tl = '0;
		r_ka = 1'b0;
		if (emit) begin
			r_status = ST_COMPLETE;
			r_cl     = declared_length(ln_q);
			r_hl     = hdr_end[15:0];
			r_ml     = ln_q.mcnt;
			r_tl     = ln_q.tcnt;
			r_ka     = !(ln_q.seen[2] && ln_q.vm[2] == 5'd5);
			phase_d  = PH_HEAD;
			term_d   = 2'd0;
			pend_d   = 1'b0;
			hbc_d    = '0;
			ln_d     = '0;
			rem_d    = '0;
		end
	end

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q  <= MAX_HEADER_RESET;
			max_body_q <= MAX_BODY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_HEADER: max_hdr_q <= cfg_data[15:0];
				CFG_MAX_BODY:   max_body_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			term_q  <= 2'd0;
			pend_q  <= 1'b0;
			hbc_q   <= '0;
			ln_q    <= '0;
			rem_q   <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			term_q  <= term_d;
			pend_q  <= pend_d;
			hbc_q   <= hbc_d;
			ln_q    <= ln_d;
			rem_q   <= rem_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status         <= r_status;
			byte_out       <= byte_in;
			body_valid     <= r_body;
			content_length <= r_cl;
			header_length  <= r_hl;
			method_length  <= r_ml;
			target_length  <= r_tl;
			keep_alive     <= r_ka;
		end
	end

endmodule

FILE: verif/http_request_stream_parser_top_tb.sv
// Self-checking testbench of the streaming HTTP request head parser.
`timescale 1ns / 100ps

module http_request_stream_parser_top_tb;
	import hrsp_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  byte_out;
		logic        body_valid;
		logic [30:0] content_length;
		logic [15:0] header_length;
		logic [15:0] method_length;
		logic [15:0] target_length;
		logic        keep_alive;
	} parse_result_t;

	// Request head predictor and store of expected per-byte answers
	class http_head_scoreboard;
		logic [15:0]   max_hdr;
		logic [30:0]   max_body;
		logic [1:0]    phase;
		logic [2:0]    term;
		bit            pend_cr;
		logic [16:0]   hbc;
		logic [3:0]    lp;
		logic [15:0]   mcnt, tcnt;
		logic [2:0]    ver;
		logic [4:0]    nm[3];
		logic [4:0]    vm[3];
		logic [2:0]    seen;
		logic [31:0]   acc;
		logic [3:0]    digits;
		logic [1:0]    err;
		logic [30:0]   body_rem;
		string         names[3];
		string         vals[3];
		parse_result_t expected_answers[$];
		int            mismatches;

		function new();
			names = '{"content-length", "transfer-encoding", "connection"};
			vals = '{"", "identity", "close"};
			max_hdr = MAX_HEADER_RESET;
			max_body = MAX_BODY_RESET;
			mismatches = 0;
			clear_request();
		endfunction

		function void set_reg(logic idx, logic [30:0] val);
			if (idx == CFG_MAX_HEADER) max_hdr = val[15:0];
			else max_body = val;
		endfunction

		function void clear_request();
			phase = PH_HEAD; term = 0; pend_cr = 0; hbc = 0; lp = LP_METHOD;
			mcnt = 0; tcnt = 0; ver = 0; seen = 0; acc = 0; digits = 0;
			err = 0; body_rem = 0;
			for (int i = 0; i < 3; i++) begin
				nm[i] = 0;
				vm[i] = 0;
			end
		endfunction

		function logic [7:0] lower(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function bit blank(logic [7:0] c);
			return c == CH_SP || c == CH_TAB;
		endfunction

		function int slot_now();
			for (int i = 0; i < 3; i++)
				if (nm[i] == names[i].len() && !seen[i]) return i;
			return -1;
		endfunction

		function void feed_name(logic [7:0] c);
			for (int i = 0; i < 3; i++) begin
				if (nm[i] == MATCH_FAIL) continue;
				if (nm[i] < names[i].len() && lower(c) == names[i][nm[i]]) nm[i] = nm[i] + 1;
				else nm[i] = MATCH_FAIL;
			end
		endfunction

		function void feed_value(logic [7:0] c);
			int s;
			logic [63:0] v;
			s = slot_now();
			if (s < 0 || vm[s] == MATCH_FAIL) return;
			if (s == 0) begin
				if (c < "0" || c > "9" || digits >= MAX_LENGTH_DIGITS) begin
					vm[0] = MATCH_FAIL;
					return;
				end
				v = 64'(acc) * 10 + 64'(c - "0");
				if (v > 64'h7FFFFFFF) begin
					vm[0] = MATCH_FAIL;
					return;
				end
				acc = v[31:0];
				digits++;
				vm[0] = 1;
			end else if (vm[s] < vals[s].len() && lower(c) == vals[s][vm[s]]) begin
				vm[s] = vm[s] + 1;
			end else begin
				vm[s] = MATCH_FAIL;
			end
		endfunction

		function void line_byte(logic [7:0] c);
			int s;
			string ver_txt;
			ver_txt = "HTTP/";
			case (lp)
				LP_METHOD: if (c == CH_SP) lp = LP_TARGET; else if (mcnt < CNT_MAX) mcnt++;
				LP_TARGET: if (c == CH_SP) lp = LP_VERSION; else if (tcnt < CNT_MAX) tcnt++;
				LP_VERSION: if (ver < 5) ver = (c == ver_txt[ver]) ? ver + 1 : 3'd7;
				LP_NAME_LEAD: begin
					if (c == CH_COLON) begin
						err |= 2'b10;
						lp = LP_VALUE_LEAD;
					end else if (!blank(c)) begin
						feed_name(c);
						lp = LP_NAME;
					end
				end
				LP_NAME: begin
					if (blank(c)) lp = LP_NAME_TRAIL;
					else if (c == CH_COLON) lp = LP_VALUE_LEAD;
					else feed_name(c);
				end
				LP_NAME_TRAIL: begin
					if (c == CH_COLON) lp = LP_VALUE_LEAD;
					else if (!blank(c)) begin
						for (int i = 0; i < 3; i++) nm[i] = MATCH_FAIL;
						lp = LP_NAME;
					end
				end
				LP_VALUE_LEAD: if (!blank(c)) begin
					feed_value(c);
					lp = LP_VALUE;
				end
				LP_VALUE: if (blank(c)) lp = LP_VALUE_TRAIL; else feed_value(c);
				LP_VALUE_TRAIL: if (!blank(c)) begin
					s = slot_now();
					if (s >= 0) vm[s] = MATCH_FAIL;
					lp = LP_VALUE;
				end
				default: ;
			endcase
		endfunction

		function void end_of_line();
			int s;
			if (lp <= LP_VERSION) begin
				if (!(lp == LP_VERSION && ver == 5 && mcnt != 0 && tcnt != 0)) err |= 2'b01;
			end else if (lp <= LP_NAME_TRAIL) begin
				err |= 2'b10;
			end else begin
				s = slot_now();
				if (s >= 0) seen[s] = 1'b1;
			end
			for (int i = 0; i < 3; i++) nm[i] = 0;
			lp = LP_NAME_LEAD;
		endfunction

		function logic [30:0] decl_len();
			return (seen[0] && vm[0] == 1) ? acc[30:0] : 31'd0;
		endfunction

		function logic [16:0] hdr_end();
			return (hbc >= 4) ? hbc - 17'd4 : 17'd0;
		endfunction

		function bit over_limits();
			return hdr_end() > {1'b0, max_hdr} || decl_len() > max_body;
		endfunction

		function bit head_broken();
			if (err != 0) return 1;
			if (seen[0] && vm[0] == MATCH_FAIL) return 1;
			if (seen[1] && vm[1] != 0 && vm[1] != 8) return 1;
			return over_limits();
		endfunction

		function void finish_request(ref parse_result_t r);
			r.status = ST_COMPLETE;
			r.content_length = decl_len();
			r.header_length = 16'(hdr_end());
			r.method_length = mcnt;
			r.target_length = tcnt;
			r.keep_alive = !(seen[2] && vm[2] == 5);
			clear_request();
		endfunction

		// Work out the answer to one accepted byte
		function void note_byte(logic [7:0] c);
			parse_result_t r;
			bit found;
			r = '0;
			r.byte_out = c;
			if (phase == PH_BAD) begin
				r.status = ST_MALFORMED;
			end else if (phase == PH_BODY) begin
				if (over_limits()) begin
					phase = PH_BAD;
					r.status = ST_MALFORMED;
				end else begin
					r.body_valid = 1;
					if (body_rem > 0) body_rem--;
					if (body_rem == 0) finish_request(r);
				end
			end else begin
				if (hbc < HBC_MAX) hbc++;
				found = (term == 3 && c == CH_LF);
				if (c == CH_CR) term = (term == 2) ? 3'd3 : 3'd1;
				else if (c == CH_LF && term == 1) term = 2;
				else term = 0;
				if (found) begin
					pend_cr = 0;
					if (head_broken()) begin
						phase = PH_BAD;
						r.status = ST_MALFORMED;
					end else if (decl_len() == 0) begin
						finish_request(r);
					end else begin
						body_rem = decl_len();
						phase = PH_BODY;
					end
				end else begin
					if (pend_cr) begin
						if (c == CH_LF) begin
							pend_cr = 0;
							end_of_line();
						end else begin
							line_byte(CH_CR);
							if (c != CH_CR) begin
								pend_cr = 0;
								line_byte(c);
							end
						end
					end else if (c == CH_CR) begin
						pend_cr = 1;
					end else begin
						line_byte(c);
					end
					if (hbc > max_hdr) begin
						phase = PH_BAD;
						r.status = ST_MALFORMED;
					end
				end
			end
			expected_answers.insert(expected_answers.size(), r);
		endfunction

		task report(string field, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", field, got, want);
			mismatches++;
		endtask

		// Compare one accepted answer with the oldest expectation
		task check_result(parse_result_t got);
			parse_result_t w;
			if (expected_answers.size() == 0) begin
				report("unexpected answer", 1, 0);
				return;
			end
			w = expected_answers.pop_front();
			if (got.status != w.status) report("status", got.status, w.status);
			if (got.byte_out != w.byte_out) report("byte_out", got.byte_out, w.byte_out);
			if (got.body_valid != w.body_valid) report("body_valid", got.body_valid, w.body_valid);
			if (got.content_length != w.content_length)
				report("content_length", got.content_length, w.content_length);
			if (got.header_length != w.header_length)
				report("header_length", got.header_length, w.header_length);
			if (got.method_length != w.method_length)
				report("method_length", got.method_length, w.method_length);
			if (got.target_length != w.target_length)
				report("target_length", got.target_length, w.target_length);
			if (got.keep_alive != w.keep_alive) report("keep_alive", got.keep_alive, w.keep_alive);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	logic [7:0]  byte_in;
	logic        out_valid, out_ready;
	logic [1:0]  status;
	logic [7:0]  byte_out;
	logic        body_valid;
	logic [30:0] content_length;
	logic [15:0] header_length, method_length, target_length;
	logic        keep_alive;
	logic        cfg_valid, cfg_ready, cfg_index;
	logic [30:0] cfg_data;

	http_head_scoreboard sb;
	bit quiet;
	int bytes_sent;
	int stall_left;
	int idle_cycles;

	http_request_stream_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .byte_out(byte_out), .body_valid(body_valid),
		.content_length(content_length), .header_length(header_length),
		.method_length(method_length), .target_length(target_length),
		.keep_alive(keep_alive),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Receiver with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Answer monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({status, byte_out, body_valid, content_length, header_length,
				method_length, target_length, keep_alive});
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= 2000) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task send_byte(logic [7:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// Wait until every expected answer has come
	task drain();
		in_valid <= 1'b0;
		while (sb.expected_answers.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task write_reg(logic idx, logic [30:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function string mixed_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
		return r;
	endfunction

	function string blanks();
		string r;
		r = "";
		repeat ($urandom_range(0, 2)) r = {r, string'($urandom_range(0, 1) ? " " : "\t")};
		return r;
	endfunction

	function string word(int lo, int hi);
		string r;
		string abc;
		abc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_./?=";
		r = "";
		repeat ($urandom_range(lo, hi)) r = {r, string'(abc[$urandom_range(0, abc.len() - 1)])};
		return r;
	endfunction

	// One well formed request with random headers and body
	task send_request();
		string s, v, methods[4], vers[3];
		int body, cap, k;
		bit cl_done;
		methods = '{"GET", "POST", "PUT", "DELETE"};
		vers = '{"HTTP/1.1", "HTTP/1.0", "HTTP/2x"};
		cap = (sb.max_body < 24) ? sb.max_body : 24;
		s = $urandom_range(0, 2) ? methods[$urandom_range(0, 3)] : word(1, 8);
		v = {"/", word(0, 10)};
		if ($urandom_range(0, 5) == 0) v = {v, "\r", word(1, 3)};
		s = {s, " ", v, " ", vers[$urandom_range(0, 2)], "\r\n"};
		body = 0;
		cl_done = 0;
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 4))
				0: begin
					if (cl_done) v = $sformatf("%0d", $urandom_range(0, 999));
					else if ($urandom_range(0, 5) == 0) v = "";
					else begin
						k = $urandom_range(0, cap);
						v = {string'($urandom_range(0, 3) == 0 ? "00" : ""),
							$sformatf("%0d", k)};
						body = k;
					end
					cl_done = 1;
					s = {s, blanks(), mixed_case("content-length"), blanks(), ":", blanks(), v,
						blanks(), "\r\n"};
				end
				1: s = {s, mixed_case("transfer-encoding"), ":", blanks(),
					$urandom_range(0, 1) ? mixed_case("identity") : "", blanks(), "\r\n"};
				2: begin
					case ($urandom_range(0, 2))
						0: v = mixed_case("close");
						1: v = "keep-alive";
						default: v = word(1, 6);
					endcase
					s = {s, mixed_case("connection"), blanks(), ":", blanks(), v, "\r\n"};
				end
				3: s = {s, "X-", word(1, 8), ":", blanks(), word(0, 12), "\r", word(0, 3),
					"\r\n"};
				default: s = {s, blanks(), mixed_case("content-lengthx"), ": 5\r\n"};
			endcase
		end
		send_text({s, "\r\n"});
		repeat (body) send_byte($urandom_range(0, 255));
	endtask

	// One malformed request, which ends parsing for the rest of the run
	task send_broken_request();
		case ($urandom_range(0, 7))
			0: send_text("GET /x\r\n\r\n");
			1: send_text("GET / HTTP/1.1\r\nHost\r\n\r\n");
			2: send_text("GET / HTTP/1.1\r\nContent-Length: 2147483648\r\n\r\n");
			3: send_text("GET / HTTP/1.1\r\nContent-Length: 00000000000\r\n\r\n");
			4: send_text("GET / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n");
			5: begin
				write_reg(CFG_MAX_HEADER, 31'd0);
				send_text("GET / HTTP/1.1\r\n\r\n");
			end
			6: begin
				write_reg(CFG_MAX_BODY, 31'd100);
				send_text("POST / HTTP/1.1\r\nContent-Length: 20\r\n\r\n");
				repeat (5) send_byte($urandom_range(0, 255));
				write_reg(CFG_MAX_BODY, 31'd10);
				send_byte(8'h41);
			end
			default: send_text("GET / HTTP/1.1\r\n : x\r\n\r\n");
		endcase
	endtask

	initial begin
		sb = new();
		quiet = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAX_HEADER;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest request, then a lone carriage return inside the target
		send_text("G / HTTP/\r\n\r\n");
		send_text("M \r/ HTTP/\r\n\r\n");

		// Random requests across several limit settings
		while (bytes_sent < 200) send_request();
		drain();
		write_reg(CFG_MAX_HEADER, 31'd65535);
		write_reg(CFG_MAX_BODY, 31'h7FFFFFFF);
		while (bytes_sent < 400) send_request();
		write_reg(CFG_MAX_HEADER, 31'd400);
		write_reg(CFG_MAX_BODY, 31'd0);
		while (bytes_sent < 550) send_request();
		write_reg(CFG_MAX_HEADER, 31'd8192);
		write_reg(CFG_MAX_BODY, 31'd1048576);
		while (bytes_sent < 650) send_request();

		// Back-to-back tail, then a broken request and noise
		quiet = 1;
		while (bytes_sent < 720) send_request();
		send_broken_request();
		repeat (40) send_byte($urandom_range(0, 255));
		drain();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
